[rtl/assert_macros.svh]
// Assertion macros shared by the priority queue RTL.
// Each macro expands to one labeled concurrent assertion, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tpq_pkg.sv]
// Package for the two-class priority queue: codes, control structs, defaults.
// Used by tpq_ring and two_class_priority_queue; no dependencies.
`default_nettype none

package tpq_pkg;

  localparam int unsigned DEF_CLASS_DEPTH = 16;
  localparam int unsigned DEF_TAG_BITS    = 32;

  localparam int unsigned REC_TAG_W  = 32;
  localparam int unsigned OCC_W      = 6;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned S_TUSER_W  = 3;
  localparam int unsigned M_TDATA_W  = 40;
  localparam int unsigned M_TUSER_W  = 3;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PEEK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Per-class ring commands issued by the controller.
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } ring_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

`default_nettype wire

[rtl/tpq_ring.sv]
// One priority class: ring buffer memory with read/write pointers and fill count.
// Depends on tpq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tpq_ring #(
  parameter int unsigned CLASS_DEPTH = tpq_pkg::DEF_CLASS_DEPTH,
  parameter int unsigned TAG_BITS    = tpq_pkg::DEF_TAG_BITS,
  localparam int unsigned CW         = $clog2(CLASS_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tpq_pkg::ring_ctrl_t  ctrl_i,
  input  wire logic [TAG_BITS-1:0]  wdata_i,
  output logic      [TAG_BITS-1:0]  rdata_o,
  output logic      [CW-1:0]        count_o,
  output tpq_pkg::ring_stat_t       stat_o
);
  import tpq_pkg::*;

  localparam int unsigned PW = $clog2(CLASS_DEPTH);

  logic [TAG_BITS-1:0] mem_q [CLASS_DEPTH];
  logic [TAG_BITS-1:0] rdata_q;
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (ctrl_i.push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CLASS_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      count_d  = count_q + CW'(1);
    end
    if (ctrl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CLASS_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      count_d  = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Read at the current head; pop advances the pointer in the same cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  assign rdata_o      = rdata_q;
  assign count_o      = count_q;
  assign stat_o.full  = (count_q == CW'(CLASS_DEPTH));
  assign stat_o.empty = (count_q == '0);

  `ASSERT_IMP(a_push_not_full, clk_i, rst_ni, ctrl_i.push, !stat_o.full, "push into full ring")
  `ASSERT_IMP(a_pop_not_empty, clk_i, rst_ni, ctrl_i.pop, ctrl_i.rd && !stat_o.empty, "bad pop")
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CW'(CLASS_DEPTH), "count overflow")

endmodule

`default_nettype wire

[rtl/two_class_priority_queue.sv]
// Top level of the two-class priority queue: stream ports, controller, result register.
// Depends on tpq_pkg, tpq_ring and assert_macros.svh.
// Results: enqueue and empty/full results are registered straight from the accepted word;
// dequeue and peek results pass through the ring memory read register, then the result
// register. Throughput: one enqueue per cycle while results are taken; a dequeue or peek
// holds off the next word until its result is loaded, due to the registered read port.
// Reset: pointers, counts and control clear at once; memories are not cleared.
`default_nettype none

`include "assert_macros.svh"

module two_class_priority_queue #(
  parameter int unsigned CLASS_DEPTH = tpq_pkg::DEF_CLASS_DEPTH,
  parameter int unsigned TAG_BITS    = tpq_pkg::DEF_TAG_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  input  wire logic [tpq_pkg::S_TDATA_W-1:0]    s_tdata_i,  // record_tag[31:0]
  input  wire logic [tpq_pkg::S_TUSER_W-1:0]    s_tuser_i,  // action[1:0], urgent[2]
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  output logic      [tpq_pkg::M_TDATA_W-1:0]    m_tdata_o,  // head_tag[31:0], occupancy[37:32]
  output logic      [tpq_pkg::M_TUSER_W-1:0]    m_tuser_o   // head_urgent[0], status[2:1]
);
  import tpq_pkg::*;

  localparam int unsigned CW = $clog2(CLASS_DEPTH + 1);

  state_e                state_q, state_d;
  ring_ctrl_t            u_ctrl, n_ctrl;
  ring_stat_t            u_stat, n_stat;
  logic [TAG_BITS-1:0]   u_rdata, n_rdata, wtag;
  logic [CW-1:0]         u_count, n_count;
  logic [CW:0]           occ_sum;

  logic                  accept, is_enq, is_deq, urgent_in, q_empty;
  logic                  load_imm, load_rd;
  logic                  sel_urg_q;
  logic                  m_valid_q, m_valid_d;
  logic [REC_TAG_W-1:0]  tag_q, tag_d;
  logic                  hurg_q, hurg_d;
  status_e               status_q, status_d;
  logic [OCC_W-1:0]      occ_q, occ_d;

  assign accept    = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == S_IDLE) && (!m_valid_q || m_tready_i);
  assign urgent_in = s_tuser_i[2];
  assign wtag      = TAG_BITS'(s_tdata_i);
  assign q_empty   = u_stat.empty && n_stat.empty;

  always_comb begin
    is_enq = 1'b0;
    is_deq = 1'b0;
    unique case (action_e'(s_tuser_i[1:0]))
      ACT_ENQ: is_enq = 1'b1;
      ACT_DEQ: is_deq = 1'b1;
      default: ;  // peek, and the unused code behaves as peek
    endcase
  end

  // Urgent head wins whenever the urgent ring holds anything.
  always_comb begin
    u_ctrl.push = accept && is_enq && urgent_in && !u_stat.full;
    n_ctrl.push = accept && is_enq && !urgent_in && !n_stat.full;
    u_ctrl.rd   = accept && !is_enq && !u_stat.empty;
    n_ctrl.rd   = accept && !is_enq && u_stat.empty && !n_stat.empty;
    u_ctrl.pop  = u_ctrl.rd && is_deq;
    n_ctrl.pop  = n_ctrl.rd && is_deq;
  end

  tpq_ring #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_urgent_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (u_ctrl),
    .wdata_i (wtag),
    .rdata_o (u_rdata),
    .count_o (u_count),
    .stat_o  (u_stat)
  );

  tpq_ring #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_normal_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (n_ctrl),
    .wdata_i (wtag),
    .rdata_o (n_rdata),
    .count_o (n_count),
    .stat_o  (n_stat)
  );

  assign occ_sum = (CW + 1)'(u_count) + (CW + 1)'(n_count)
                 + (CW + 1)'(u_ctrl.push || n_ctrl.push);

  assign load_imm = accept && (is_enq || q_empty);
  assign load_rd  = (state_q == S_READ);

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    tag_d     = tag_q;
    hurg_d    = hurg_q;
    status_d  = status_q;
    occ_d     = occ_q;
    if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (load_imm) begin
          m_valid_d = 1'b1;
          tag_d     = '0;
          hurg_d    = 1'b0;
          occ_d     = OCC_W'(occ_sum);
          if (is_enq) begin
            status_d = (u_ctrl.push || n_ctrl.push) ? ST_OK : ST_FULL;
          end else begin
            status_d = ST_EMPTY;
          end
        end else if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        m_valid_d = 1'b1;
        tag_d     = REC_TAG_W'(sel_urg_q ? u_rdata : n_rdata);
        hurg_d    = sel_urg_q;
        status_d  = ST_OK;
        occ_d     = OCC_W'(occ_sum);
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    hurg_q   <= hurg_d;
    status_q <= status_d;
    occ_q    <= occ_d;
    if (accept) begin
      sel_urg_q <= !u_stat.empty;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {(M_TDATA_W - REC_TAG_W - OCC_W)'(0), occ_q, tag_q};
  assign m_tuser_o  = {status_q, hurg_q};

  `ASSERT_NEVER(a_one_class_read, clk_i, rst_ni, u_ctrl.rd && n_ctrl.rd, "both rings read")
  `ASSERT_NEXT(a_read_then_load, clk_i, rst_ni, u_ctrl.rd || n_ctrl.rd, load_rd && !m_valid_q, "read slot busy")
  `ASSERT_IMP(a_empty_occ_zero, clk_i, rst_ni, m_valid_q && (status_q == ST_EMPTY), occ_q == '0, "empty with entries")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for two_class_priority_queue: directed rows, then random traffic.
// Tracks both priority classes in its own queues and checks every result word.
// Depends on tpq_pkg and the two_class_priority_queue RTL.
`timescale 1ns / 1ps

module tb_top;
  import tpq_pkg::*;

  localparam int unsigned CLASS_DEPTH = DEF_CLASS_DEPTH;
  localparam logic [1:0]  ACT_UNDEF   = 2'd3;  // decodes as a peek
  localparam int          HOLD_CYCLES = 300;

  typedef struct packed {
    logic [REC_TAG_W-1:0] tag;
    logic                 urg;
    status_e              status;
    logic [OCC_W-1:0]     occ;
  } head_result_t;

  typedef struct {
    logic [1:0]           action;
    logic [REC_TAG_W-1:0] tag;
    logic                 urg;
    int                   reps;
    bit                   typed;
    status_e              want_st;
    logic [OCC_W-1:0]     want_occ;
  } req_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_tvalid_i;
  logic                 s_tready_o;
  logic [S_TDATA_W-1:0] s_tdata_i;   // record_tag[31:0]
  logic [S_TUSER_W-1:0] s_tuser_i;   // action[1:0], urgent[2]
  logic                 m_tvalid_o;
  logic                 m_tready_i;
  logic [M_TDATA_W-1:0] m_tdata_o;   // head_tag[31:0], occupancy[37:32]
  logic [M_TUSER_W-1:0] m_tuser_o;   // head_urgent[0], status[2:1]

  // Word on offer: typed expectation held beside the data until accepted
  bit           offer_typed;
  head_result_t offer_want;

  logic [REC_TAG_W-1:0] urgent_tags[$];
  logic [REC_TAG_W-1:0] normal_tags[$];
  head_result_t         pending_heads[$];
  req_row_t             dir_rows[$];

  int fail_count    = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  two_class_priority_queue u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Apply one word to the shadow queues and return the head result it produces.
  function automatic head_result_t predict_head(logic [1:0] act, logic [REC_TAG_W-1:0] tag,
                                                logic urg);
    head_result_t r;
    r = '0;
    r.status = ST_OK;
    if (act == ACT_ENQ) begin
      if (urg) begin
        if (urgent_tags.size() >= CLASS_DEPTH) r.status = ST_FULL;
        else urgent_tags.push_back(tag);
      end else begin
        if (normal_tags.size() >= CLASS_DEPTH) r.status = ST_FULL;
        else normal_tags.push_back(tag);
      end
    end else if (urgent_tags.size() == 0 && normal_tags.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.urg = (urgent_tags.size() != 0);
      r.tag = r.urg ? urgent_tags[0] : normal_tags[0];
      if (act == ACT_DEQ) begin
        if (r.urg) void'(urgent_tags.pop_front());
        else void'(normal_tags.pop_front());
      end
    end
    r.occ = OCC_W'(urgent_tags.size() + normal_tags.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    head_result_t want;
    head_result_t got;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        got.tag    = m_tdata_o[31:0];
        got.occ    = m_tdata_o[37:32];
        got.urg    = m_tuser_o[0];
        got.status = status_e'(m_tuser_o[2:1]);
        if (pending_heads.size() == 0) begin
          $error("result word with nothing pending: tag %h status %0d", got.tag, got.status);
          fail_count++;
        end else begin
          want = pending_heads.pop_front();
          if (got.tag !== want.tag) begin
            $error("head_tag: expected %h, got %h", want.tag, got.tag);
            fail_count++;
          end
          if (got.urg !== want.urg) begin
            $error("head_urgent: expected %0d, got %0d", want.urg, got.urg);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.occ !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
            fail_count++;
          end
        end
      end
      if (s_tvalid_i && s_tready_o) begin
        want = predict_head(s_tuser_i[1:0], s_tdata_i, s_tuser_i[2]);
        pending_heads.push_back(offer_typed ? offer_want : want);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_requests) begin
        m_tready_i = 1'b0;
        holds_done++;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        m_tready_i = ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [REC_TAG_W-1:0] tag,
                           input logic urg, input bit typed, input head_result_t want);
    int gap;
    gap = 0;
    @(negedge clk_i);
    while (gap < 12 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      s_tdata_i  = $urandom;
      s_tuser_i  = S_TUSER_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i  = 1'b1;
    s_tdata_i   = tag;
    s_tuser_i   = {urg, act};
    offer_typed = typed;
    offer_want  = want;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic add_row(input logic [1:0] act, input logic [REC_TAG_W-1:0] tag,
                         input logic urg, input int reps, input bit typed,
                         input status_e st, input logic [OCC_W-1:0] occ);
    req_row_t row;
    row.action   = act;
    row.tag      = tag;
    row.urg      = urg;
    row.reps     = reps;
    row.typed    = typed;
    row.want_st  = st;
    row.want_occ = occ;
    dir_rows.push_back(row);
  endtask

  // Random bursts: each burst leans toward filling, draining or mixing,
  // and toward one class, so both stores reach full and empty often.
  task automatic run_bursts(input int n_words);
    int sent;
    int burst;
    int mode;
    int urg_pct;
    int r;
    logic [1:0] act;
    logic [REC_TAG_W-1:0] tag;
    sent = 0;
    while (sent < n_words) begin
      burst = $urandom_range(5, 40);
      if (burst > n_words - sent) burst = n_words - sent;
      mode  = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0: urg_pct = 10;
        1: urg_pct = 50;
        default: urg_pct = 90;
      endcase
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < (mode == 0 ? 70 : (mode == 1 ? 20 : 45))) act = ACT_ENQ;
        else if (r < (mode == 2 ? 80 : 85)) act = ACT_DEQ;
        else if (r < 95) act = ACT_PEEK;
        else act = ACT_UNDEF;
        case ($urandom_range(0, 15))
          0: tag = '0;
          1: tag = '1;
          default: tag = $urandom;
        endcase
        send_word(act, tag, $urandom_range(0, 99) < urg_pct, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    head_result_t want;
    req_row_t     row;
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = '0;
    offer_typed = 1'b0;
    offer_want  = '0;

    // Empty queue, all head actions, then enqueue extremes of the tag
    add_row(ACT_DEQ,   32'h0,        1'b0, 1,  1'b1, ST_EMPTY, 6'd0);
    add_row(ACT_PEEK,  32'hFFFFFFFF, 1'b1, 1,  1'b1, ST_EMPTY, 6'd0);
    add_row(ACT_UNDEF, 32'h0,        1'b1, 1,  1'b1, ST_EMPTY, 6'd0);
    add_row(ACT_ENQ,   32'hFFFFFFFF, 1'b0, 1,  1'b1, ST_OK,    6'd1);
    add_row(ACT_ENQ,   32'h0,        1'b1, 1,  1'b1, ST_OK,    6'd2);
    add_row(ACT_PEEK,  32'h0,        1'b0, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_UNDEF, 32'h0,        1'b0, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_DEQ,   32'h0,        1'b1, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_DEQ,   32'h0,        1'b0, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_DEQ,   32'h0,        1'b0, 1,  1'b1, ST_EMPTY, 6'd0);
    // Fill the urgent store, then the normal one, and overflow each
    add_row(ACT_ENQ,   32'hA5A50000, 1'b1, 16, 1'b0, ST_OK,    6'd0);
    add_row(ACT_ENQ,   32'h12345678, 1'b1, 1,  1'b1, ST_FULL,  6'd16);
    add_row(ACT_ENQ,   32'h5A5A0000, 1'b0, 16, 1'b0, ST_OK,    6'd0);
    add_row(ACT_ENQ,   32'h87654321, 1'b0, 1,  1'b1, ST_FULL,  6'd32);
    add_row(ACT_ENQ,   32'hFFFFFFFF, 1'b1, 1,  1'b1, ST_FULL,  6'd32);
    add_row(ACT_PEEK,  32'h0,        1'b0, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_DEQ,   32'h0,        1'b0, 32, 1'b0, ST_OK,    6'd0);
    add_row(ACT_DEQ,   32'h0,        1'b0, 1,  1'b1, ST_EMPTY, 6'd0);
    // Interleave classes: urgent words must overtake earlier normal ones
    add_row(ACT_ENQ,   32'h80000001, 1'b0, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_ENQ,   32'h80000002, 1'b1, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_ENQ,   32'h80000003, 1'b0, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_ENQ,   32'h80000004, 1'b1, 1,  1'b0, ST_OK,    6'd0);
    add_row(ACT_DEQ,   32'h0,        1'b0, 4,  1'b0, ST_OK,    6'd0);

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      want = '0;
      want.status = row.want_st;
      want.occ    = row.want_occ;
      for (int k = 0; k < row.reps; k++) begin
        send_word(row.action, row.tag + k, row.urg, row.typed, want);
      end
    end

    tx_idle_pct = 0;  rx_stall_pct = 0;  run_bursts(400);
    tx_idle_pct = 70; rx_stall_pct = 0;  run_bursts(350);
    tx_idle_pct = 0;  rx_stall_pct = 70; run_bursts(350);
    tx_idle_pct = 6;  rx_stall_pct = 6;  run_bursts(400);

    // Long receiver hold-off while words keep coming: the block must fill and stall
    tx_idle_pct = 0;  rx_stall_pct = 0;
    hold_requests++;
    run_bursts(100);

    tx_idle_pct = 0;  rx_stall_pct = 0;  run_bursts(150);

    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    while (pending_heads.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
